// ===== design/oriented_primitive_aabb_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the oriented primitive box block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_PRIMITIVE_AABB_ASSERT_SVH
`define ORIENTED_PRIMITIVE_AABB_ASSERT_SVH

// same-cycle implication, held off during reset
`define OPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("opa: same-cycle check failed");

// next-cycle implication, held off during reset
`define OPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("opa: next-cycle check failed");

`endif

// ===== design/opa_pkg.sv =====
// ----------------------------------------------------------------------------
// opa_pkg
// Widths, formats and primitive kind codes for the oriented primitive box.
// ----------------------------------------------------------------------------
package opa_pkg;

    // coordinate and quaternion formats
    localparam int COORD_W  = 32;              // signed Q16.16
    localparam int SIZE_W   = COORD_W - 1;     // unsigned sizes
    localparam int QUAT_W   = 16;              // signed Q1.14
    localparam int QF       = QUAT_W - 2;      // quaternion fraction bits

    // internal widths
    localparam int PROD_W   = 2 * QUAT_W;      // quaternion part product
    localparam int ENTRY_W  = 2 * QUAT_W + 4;  // rotation entry at 2*QF fraction bits
    localparam int MAG_W    = QF + 2;          // rounded entry magnitude, up to 2.0
    localparam int MUL_W    = MAG_W + SIZE_W;  // entry times size
    localparam int SCALED_W = SIZE_W + 2;      // rounded scaled size
    localparam int HALF_W   = SCALED_W + 2;    // sum of three scaled sizes
    localparam int SUM_W    = HALF_W + 2;      // centre plus or minus half

    typedef enum logic [1:0] {
        KIND_SPHERE  = 2'd0,
        KIND_CAPSULE = 2'd1,
        KIND_BOX     = 2'd2,
        KIND_POINT   = 2'd3
    } kind_t;

endpackage

// ===== design/oriented_primitive_aabb.sv =====
// An accepted input beat passes through stages S1 to S5; its result beat is offered from S5.
// Throughput: one beat per cycle; a new primitive can enter every cycle unless a result stall backs up the pipe.
// Five register stages, each with its own valid bit; a stall fills bubbles then holds.
// Reset (rst_n low, asynchronous) empties every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
// oriented_primitive_aabb
// Axis-aligned bounding box of a sphere, capsule or box with a quaternion
// orientation, in fixed point, saturated to the coordinate range.
// ----------------------------------------------------------------------------
module oriented_primitive_aabb
    import opa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // input beat
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                command,
    input  logic signed [COORD_W-1:0] center_x,
    input  logic signed [COORD_W-1:0] center_y,
    input  logic signed [COORD_W-1:0] center_z,
    input  logic signed [QUAT_W-1:0]  quat_w,
    input  logic signed [QUAT_W-1:0]  quat_x,
    input  logic signed [QUAT_W-1:0]  quat_y,
    input  logic signed [QUAT_W-1:0]  quat_z,
    input  logic [SIZE_W-1:0]         size_x,
    input  logic [SIZE_W-1:0]         size_y,
    input  logic [SIZE_W-1:0]         size_z,

    // result beat
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic signed [COORD_W-1:0] min_x,
    output logic signed [COORD_W-1:0] min_y,
    output logic signed [COORD_W-1:0] min_z,
    output logic signed [COORD_W-1:0] max_x,
    output logic signed [COORD_W-1:0] max_y,
    output logic signed [COORD_W-1:0] max_z
);

    // ------------------------------------------------------------------------
    // Pipeline map
    //   S1: the nine quaternion part products (16x16 each)
    //   S2: rotation entries, rounded to unsigned Q2.14, clamped to 2.0, kept as magnitudes.
    //       Only |R| is ever used, so the entry signs are dropped here.
    //   S3: |R[i][j]| * size[j], rounded to Q16.16 (nine 16x31 multipliers)
    //   S4: half extent per axis, selected by the primitive kind
    //   S5: centre -/+ half extent, saturated; this is the output register
    // ------------------------------------------------------------------------

    // product slots in S1
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_WZ = 4;
    localparam int P_XZ = 5;
    localparam int P_WY = 6;
    localparam int P_YZ = 7;
    localparam int P_WX = 8;

    localparam logic signed [ENTRY_W-1:0] ENTRY_ONE = ENTRY_W'(1) <<< (2 * QF);
    localparam logic [ENTRY_W-1:0]        ENTRY_RND = ENTRY_W'(1) << (QF - 1);
    localparam logic [ENTRY_W-1:0]        ENTRY_CAP = ENTRY_W'(1) << (QF + 1);
    localparam logic [MUL_W-1:0]          MUL_RND   = MUL_W'(1) << (QF - 1);
    localparam logic signed [SUM_W-1:0]   SAT_HI    = SUM_W'((64'(1) << (COORD_W - 1)) - 64'(1));
    localparam logic signed [SUM_W-1:0]   SAT_LO    = -SAT_HI - SUM_W'(1);

    // entry at 2*QF fraction bits -> rounded magnitude at QF bits, clamped to 2.0
    function automatic logic [MAG_W-1:0] reduce_mag(input logic signed [ENTRY_W-1:0] e);
        logic [ENTRY_W-1:0] m;
        logic [ENTRY_W-1:0] r;
        m = e[ENTRY_W-1] ? $unsigned(-e) : $unsigned(e);
        r = (m + ENTRY_RND) >> QF;
        if (r > ENTRY_CAP)
        begin
            r = ENTRY_CAP;
        end
        return r[MAG_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v;
        if (v > SAT_HI)
        begin
            t = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            t = SAT_LO;
        end
        return t[COORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Flow control: a stage takes a new beat when it is empty or its
    // contents move on in the same cycle.
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || !result_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign item_stall   = !rdy1;
    assign result_valid = v5_reg;

    logic ld1, ld2, ld3, ld4, ld5;
    assign ld1 = rdy1 && item_valid;
    assign ld2 = rdy2 && v1_reg;
    assign ld3 = rdy3 && v2_reg;
    assign ld4 = rdy4 && v3_reg;
    assign ld5 = rdy5 && v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= item_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------------
    // S1: quaternion part products
    // ------------------------------------------------------------------------
    kind_t                      kind1_reg;
    logic signed [COORD_W-1:0]  c1_reg [3];
    logic [SIZE_W-1:0]          s1_reg [3];
    logic signed [PROD_W-1:0]   prod_reg [9];
    logic signed [PROD_W-1:0]   prod_next [9];

    always_comb
    begin
        prod_next[P_XX] = quat_x * quat_x;
        prod_next[P_YY] = quat_y * quat_y;
        prod_next[P_ZZ] = quat_z * quat_z;
        prod_next[P_XY] = quat_x * quat_y;
        prod_next[P_WZ] = quat_w * quat_z;
        prod_next[P_XZ] = quat_x * quat_z;
        prod_next[P_WY] = quat_w * quat_y;
        prod_next[P_YZ] = quat_y * quat_z;
        prod_next[P_WX] = quat_w * quat_x;
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            kind1_reg <= kind_t'(command);
            c1_reg[0] <= center_x;
            c1_reg[1] <= center_y;
            c1_reg[2] <= center_z;
            s1_reg[0] <= size_x;
            s1_reg[1] <= size_y;
            s1_reg[2] <= size_z;
            prod_reg  <= prod_next;
        end
    end

    // ------------------------------------------------------------------------
    // S2: rotation matrix entries, as rounded and clamped magnitudes
    // ------------------------------------------------------------------------
    kind_t                      kind2_reg;
    logic signed [COORD_W-1:0]  c2_reg [3];
    logic [SIZE_W-1:0]          s2_reg [3];
    logic [MAG_W-1:0]           mag_reg [3][3];
    logic [MAG_W-1:0]           mag_next [3][3];
    logic signed [ENTRY_W-1:0]  pe [9];
    logic signed [ENTRY_W-1:0]  ent [3][3];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            pe[k] = ENTRY_W'(prod_reg[k]);
        end
        ent[0][0] = ENTRY_ONE - ((pe[P_YY] + pe[P_ZZ]) <<< 1);
        ent[0][1] = (pe[P_XY] - pe[P_WZ]) <<< 1;
        ent[0][2] = (pe[P_XZ] + pe[P_WY]) <<< 1;
        ent[1][0] = (pe[P_XY] + pe[P_WZ]) <<< 1;
        ent[1][1] = ENTRY_ONE - ((pe[P_XX] + pe[P_ZZ]) <<< 1);
        ent[1][2] = (pe[P_YZ] - pe[P_WX]) <<< 1;
        ent[2][0] = (pe[P_XZ] - pe[P_WY]) <<< 1;
        ent[2][1] = (pe[P_YZ] + pe[P_WX]) <<< 1;
        ent[2][2] = ENTRY_ONE - ((pe[P_XX] + pe[P_YY]) <<< 1);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mag_next[i][j] = reduce_mag(ent[i][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            kind2_reg <= kind1_reg;
            c2_reg    <= c1_reg;
            s2_reg    <= s1_reg;
            mag_reg   <= mag_next;
        end
    end

    // ------------------------------------------------------------------------
    // S3: |R[i][j]| * size[j], rounded half away from zero to Q16.16
    // ------------------------------------------------------------------------
    kind_t                      kind3_reg;
    logic signed [COORD_W-1:0]  c3_reg [3];
    logic [SIZE_W-1:0]          rad3_reg;
    logic [SCALED_W-1:0]        scl_reg [3][3];
    logic [SCALED_W-1:0]        scl_next [3][3];
    logic [MUL_W-1:0]           mul [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mul[i][j]      = MUL_W'(mag_reg[i][j]) * MUL_W'(s2_reg[j]);
                scl_next[i][j] = SCALED_W'((mul[i][j] + MUL_RND) >> QF);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            kind3_reg <= kind2_reg;
            c3_reg    <= c2_reg;
            rad3_reg  <= s2_reg[0];
            scl_reg   <= scl_next;
        end
    end

    // ------------------------------------------------------------------------
    // S4: half extent per axis
    // ------------------------------------------------------------------------
    logic signed [COORD_W-1:0]  c4_reg [3];
    logic [HALF_W-1:0]          half_reg [3];
    logic [HALF_W-1:0]          half_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (kind3_reg)
                KIND_SPHERE:  half_next[i] = HALF_W'(rad3_reg);
                KIND_CAPSULE: half_next[i] = HALF_W'(scl_reg[i][1]) + HALF_W'(rad3_reg);
                KIND_BOX:     half_next[i] = HALF_W'(scl_reg[i][0]) + HALF_W'(scl_reg[i][1])
                                           + HALF_W'(scl_reg[i][2]);
                KIND_POINT:   half_next[i] = '0;
                default:      half_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            c4_reg   <= c3_reg;
            half_reg <= half_next;
        end
    end

    // ------------------------------------------------------------------------
    // S5: corners, saturated; held while the consumer stalls
    // ------------------------------------------------------------------------
    logic signed [COORD_W-1:0]  lo_reg [3];
    logic signed [COORD_W-1:0]  hi_reg [3];
    logic signed [COORD_W-1:0]  lo_next [3];
    logic signed [COORD_W-1:0]  hi_next [3];
    logic signed [SUM_W-1:0]    cw [3];
    logic signed [SUM_W-1:0]    hw [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cw[i]      = SUM_W'(c4_reg[i]);
            hw[i]      = $signed(SUM_W'(half_reg[i]));
            lo_next[i] = saturate(cw[i] - hw[i]);
            hi_next[i] = saturate(cw[i] + hw[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign min_x = lo_reg[0];
    assign min_y = lo_reg[1];
    assign min_z = lo_reg[2];
    assign max_x = hi_reg[0];
    assign max_y = hi_reg[1];
    assign max_z = hi_reg[2];

endmodule

// ===== design/opa_checker.sv =====
// ----------------------------------------------------------------------------
// opa_checker
// Port-level checks for oriented_primitive_aabb, bound to the top level.
// ----------------------------------------------------------------------------
`include "oriented_primitive_aabb_assert.svh"

module opa_checker
    import opa_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_stall,
    input logic                      result_valid,
    input logic                      result_stall,
    input logic signed [COORD_W-1:0] min_x,
    input logic signed [COORD_W-1:0] min_y,
    input logic signed [COORD_W-1:0] min_z,
    input logic signed [COORD_W-1:0] max_x,
    input logic signed [COORD_W-1:0] max_y,
    input logic signed [COORD_W-1:0] max_z
);

    // half extents are never negative, so a box is never inside out
    `OPA_ASSERT_IMPLY(a_box_ordered, clk, rst_n, result_valid,
        (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))

    // the input side only backs up when the whole pipe is full and blocked
    `OPA_ASSERT_IMPLY(a_stall_from_output, clk, rst_n, item_stall,
        result_valid && result_stall)

    // a stalled result beat stays offered
    `OPA_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall,
        result_valid)

    // bubbles are squeezed out: an empty output never pushes back on the input
    `OPA_ASSERT_IMPLY(a_no_stall_when_empty, clk, rst_n, !result_valid,
        !item_stall)

endmodule

bind oriented_primitive_aabb opa_checker u_opa_checker (.*);
